// ===== hdl/mmc_pkg.sv =====
// shared types, codes and helpers for the matrix multiply core
`timescale 1ns / 1ps
`default_nettype none

package mmc_pkg;

   // default sizes handed to the top level parameters
   localparam int MAX_DIM_DEFAULT    = 8;
   localparam int ELEM_WIDTH_DEFAULT = 16;

   // fixed field widths
   localparam int CFG_W       = 4;
   localparam int KIND_W      = 2;
   localparam int IDX_FIELD_W = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int OUT_W       = 32;

   // request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_A  = 2'd0,
      KIND_LOAD_B  = 2'd1,
      KIND_COMPUTE = 2'd2
   } kind_type;

   // control register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_A_ROWS = 2'd0,
      CSR_A_COLS = 2'd1,
      CSR_B_ROWS = 2'd2,
      CSR_B_COLS = 2'd3
   } csr_reg_type;

   // sequencer states
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_DRAIN
   } seq_state_type;

   // tag that travels beside each operand pair through the mac pipeline
   typedef struct packed {
      logic                   valid;
      logic                   first_k;
      logic                   last_k;
      logic                   last_item;
      logic [IDX_FIELD_W-1:0] row;
      logic [IDX_FIELD_W-1:0] col;
   } mac_tag_type;

   // clamp a dimension register into 1..max_dim
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] value,
                                                  input logic [CFG_W-1:0] max_dim);
      logic [CFG_W-1:0] result;
      if (value == '0) begin
         result = CFG_W'(1);
      end else if (value > max_dim) begin
         result = max_dim;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/mmc_elem_store.sv =====
// element store: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mmc_elem_store #(
   parameter  int DEPTH  = 64,
   parameter  int WIDTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/mmc_mac_pipe.sv =====
// multiply, accumulate and result register stages
`timescale 1ns / 1ps
`default_nettype none

module mmc_mac_pipe
   import mmc_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mac_tag_type            tag_in,
   input  wire logic [ELEM_WIDTH-1:0]  a_elem,
   input  wire logic [ELEM_WIDTH-1:0]  b_elem,
   input  wire logic                   err_req,
   output      logic                   rsp_valid,
   output      logic [IDX_FIELD_W-1:0] rsp_out_row,
   output      logic [IDX_FIELD_W-1:0] rsp_out_col,
   output      logic signed [OUT_W-1:0] rsp_out_value,
   output      logic                   rsp_dim_error,
   output      logic                   rsp_last
);

   localparam int MUL_W = (2 * ELEM_WIDTH > OUT_W) ? 2 * ELEM_WIDTH : OUT_W + 1;
   localparam int ACC_W = OUT_W + $clog2(MAX_DIM);

   localparam logic signed [MUL_W-1:0] MUL_MAX =
      $signed({{(MUL_W-OUT_W){1'b0}}, 1'b0, {(OUT_W-1){1'b1}}});
   localparam logic signed [MUL_W-1:0] MUL_MIN =
      $signed({{(MUL_W-OUT_W){1'b1}}, 1'b1, {(OUT_W-1){1'b0}}});
   localparam logic signed [ACC_W-1:0] ACC_MAX =
      $signed({{(ACC_W-OUT_W){1'b0}}, 1'b0, {(OUT_W-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] ACC_MIN =
      $signed({{(ACC_W-OUT_W){1'b1}}, 1'b1, {(OUT_W-1){1'b0}}});
   localparam logic signed [OUT_W-1:0] OUT_MAX = $signed({1'b0, {(OUT_W-1){1'b1}}});
   localparam logic signed [OUT_W-1:0] OUT_MIN = $signed({1'b1, {(OUT_W-1){1'b0}}});

   logic signed [2*ELEM_WIDTH-1:0] prod_raw;
   logic signed [MUL_W-1:0]        prod_wide;
   logic signed [OUT_W-1:0]        prod_in, prod_ff;
   mac_tag_type                    tag_in_q, tag_ff;
   logic signed [ACC_W-1:0]        acc_base, sum, acc_in, acc_ff;
   logic signed [OUT_W-1:0]        sum_sat;

   logic                   rsp_valid_in, rsp_valid_ff;
   logic [IDX_FIELD_W-1:0] rsp_row_in, rsp_row_ff;
   logic [IDX_FIELD_W-1:0] rsp_col_in, rsp_col_ff;
   logic signed [OUT_W-1:0] rsp_value_in, rsp_value_ff;
   logic                   rsp_error_in, rsp_error_ff;
   logic                   rsp_last_in, rsp_last_ff;

   // product stage: exact product, saturated to the output width
   always_comb begin
      prod_raw  = (2*ELEM_WIDTH)'($signed(a_elem)) * (2*ELEM_WIDTH)'($signed(b_elem));
      prod_wide = MUL_W'(prod_raw);
      priority if (prod_wide > MUL_MAX) begin
         prod_in = OUT_MAX;
      end else if (prod_wide < MUL_MIN) begin
         prod_in = OUT_MIN;
      end else begin
         prod_in = prod_wide[OUT_W-1:0];
      end
      tag_in_q = tag_in;
   end

   // accumulate stage: exact running sum, saturated when the element closes
   always_comb begin
      acc_base = tag_ff.first_k ? '0 : acc_ff;
      sum      = acc_base + ACC_W'(prod_ff);
      acc_in   = tag_ff.valid ? sum : acc_ff;
      priority if (sum > ACC_MAX) begin
         sum_sat = OUT_MAX;
      end else if (sum < ACC_MIN) begin
         sum_sat = OUT_MIN;
      end else begin
         sum_sat = sum[OUT_W-1:0];
      end
   end

   // result register select
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (err_req) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = '0;
         rsp_col_in   = '0;
         rsp_value_in = '0;
         rsp_error_in = 1'b1;
         rsp_last_in  = 1'b1;
      end else if (tag_ff.valid && tag_ff.last_k) begin
         rsp_valid_in = 1'b1;
         rsp_row_in   = tag_ff.row;
         rsp_col_in   = tag_ff.col;
         rsp_value_in = sum_sat;
         rsp_error_in = 1'b0;
         rsp_last_in  = tag_ff.last_item;
      end
   end

   // control registers and tag
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_ff.valid <= tag_in_q.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      tag_ff.first_k   <= tag_in_q.first_k;
      tag_ff.last_k    <= tag_in_q.last_k;
      tag_ff.last_item <= tag_in_q.last_item;
      tag_ff.row       <= tag_in_q.row;
      tag_ff.col       <= tag_in_q.col;
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff          <= prod_in;
      acc_ff           <= acc_in;
      rsp_row_ff       <= rsp_row_in;
      rsp_col_ff       <= rsp_col_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_error_ff     <= rsp_error_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_dim_error = rsp_error_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/matrix_multiply_core.sv =====
// matrix multiply core: operand stores, sequencer and mac pipeline
//
// Load an element of A or B with start high while busy is low, req_kind
// selecting the store and req_row_index / req_col_index the entry; a load
// gives no result. Loads outside the store are dropped.
// A compute request (KIND_COMPUTE) forms C = A * B over the dimensions held
// in the four control registers, which the user must write over the csr_
// channel only while idle, unchecked by the core (csr_ready is always high).
// Results come out in row-major order, one per rsp_valid cycle, with
// rsp_last on the final one; the receiver must take every result.
// Mismatched inner dimensions give one result with rsp_dim_error and
// rsp_last set, the cycle after the start transfer; busy stays low.
// A compute runs one multiply-accumulate per cycle, the rate of the single
// read port on each store; busy stays high up to and including the last
// result, and each element's sum passes the read, product and result registers.
// Reset clears the sequencer and sets all dimensions to 1; store contents
// are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_core
   import mmc_pkg::*;
#(
   parameter int MAX_DIM    = MAX_DIM_DEFAULT,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output      logic                    busy,
   input  wire logic [KIND_W-1:0]       req_kind,
   input  wire logic [IDX_FIELD_W-1:0]  req_row_index,
   input  wire logic [IDX_FIELD_W-1:0]  req_col_index,
   input  wire logic [ELEM_WIDTH-1:0]   req_element_value,
   input  wire logic                    csr_valid,
   output      logic                    csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]        csr_data,
   output      logic                    rsp_valid,
   output      logic [IDX_FIELD_W-1:0]  rsp_out_row,
   output      logic [IDX_FIELD_W-1:0]  rsp_out_col,
   output      logic signed [OUT_W-1:0] rsp_out_value,
   output      logic                    rsp_dim_error,
   output      logic                    rsp_last
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam logic [CFG_W-1:0] MAX_DIM_C = CFG_W'(MAX_DIM);

   seq_state_type    state_in, state_ff;
   logic [IDX_W-1:0] i_in, i_ff, j_in, j_ff, k_in, k_ff;
   logic [CFG_W-1:0] a_rows_in, a_rows_ff, a_cols_in, a_cols_ff;
   logic [CFG_W-1:0] b_rows_in, b_rows_ff, b_cols_in, b_cols_ff;
   logic [CFG_W-1:0] ar, ac, br, bc;
   logic             dims_match, i_end, j_end, k_end;
   logic             load_ok, a_wr_en, b_wr_en, err_req, issue;
   logic [ADDR_W-1:0] load_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_WIDTH-1:0] a_rd_data, b_rd_data;
   mac_tag_type      s1_tag_in, s1_tag_ff;

   // control register writes
   always_comb begin
      a_rows_in = a_rows_ff;
      a_cols_in = a_cols_ff;
      b_rows_in = b_rows_ff;
      b_cols_in = b_cols_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_A_ROWS: a_rows_in = csr_data;
            CSR_A_COLS: a_cols_in = csr_data;
            CSR_B_ROWS: b_rows_in = csr_data;
            CSR_B_COLS: b_cols_in = csr_data;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // clamped dimensions and loop ends
   always_comb begin
      ar         = clamp_dim(a_rows_ff, MAX_DIM_C);
      ac         = clamp_dim(a_cols_ff, MAX_DIM_C);
      br         = clamp_dim(b_rows_ff, MAX_DIM_C);
      bc         = clamp_dim(b_cols_ff, MAX_DIM_C);
      dims_match = (ac == br);
      i_end      = (CFG_W'(i_ff) == ar - CFG_W'(1));
      j_end      = (CFG_W'(j_ff) == bc - CFG_W'(1));
      k_end      = (CFG_W'(k_ff) == ac - CFG_W'(1));
   end

   // store addresses
   always_comb begin
      load_ok   = ({1'b0, req_row_index} < MAX_DIM_C) && ({1'b0, req_col_index} < MAX_DIM_C);
      load_addr = ADDR_W'(ADDR_W'(req_row_index) * ADDR_W'(MAX_DIM))
                  + ADDR_W'(req_col_index);
      a_rd_addr = ADDR_W'(ADDR_W'(i_ff) * ADDR_W'(MAX_DIM)) + ADDR_W'(k_ff);
      b_rd_addr = ADDR_W'(ADDR_W'(k_ff) * ADDR_W'(MAX_DIM)) + ADDR_W'(j_ff);
   end

   // sequencer: loads in idle, then one read pair per cycle over i, j, k
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      a_wr_en  = 1'b0;
      b_wr_en  = 1'b0;
      err_req  = 1'b0;
      issue    = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  KIND_LOAD_A: a_wr_en = load_ok;
                  KIND_LOAD_B: b_wr_en = load_ok;
                  KIND_COMPUTE: begin
                     if (dims_match) begin
                        state_in = SEQ_RUN;
                        i_in     = '0;
                        j_in     = '0;
                        k_in     = '0;
                     end else begin
                        err_req = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         SEQ_RUN: begin
            issue = 1'b1;
            if (k_end) begin
               k_in = '0;
               if (j_end) begin
                  j_in = '0;
                  if (i_end) begin
                     state_in = SEQ_DRAIN;
                  end else begin
                     i_in = i_ff + IDX_W'(1);
                  end
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         SEQ_DRAIN: begin
            if (rsp_valid && rsp_last) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign busy = (state_ff != SEQ_IDLE);

   // tag for the read issued this cycle
   always_comb begin
      s1_tag_in.valid     = issue;
      s1_tag_in.first_k   = (k_ff == '0);
      s1_tag_in.last_k    = k_end;
      s1_tag_in.last_item = i_end && j_end;
      s1_tag_in.row       = IDX_FIELD_W'(i_ff);
      s1_tag_in.col       = IDX_FIELD_W'(j_ff);
   end

   // control registers and tag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= SEQ_IDLE;
         a_rows_ff       <= CFG_W'(1);
         a_cols_ff       <= CFG_W'(1);
         b_rows_ff       <= CFG_W'(1);
         b_cols_ff       <= CFG_W'(1);
         s1_tag_ff.valid <= 1'b0;
      end else begin
         state_ff        <= state_in;
         a_rows_ff       <= a_rows_in;
         a_cols_ff       <= a_cols_in;
         b_rows_ff       <= b_rows_in;
         b_cols_ff       <= b_cols_in;
         s1_tag_ff.valid <= s1_tag_in.valid;
      end
      s1_tag_ff.first_k   <= s1_tag_in.first_k;
      s1_tag_ff.last_k    <= s1_tag_in.last_k;
      s1_tag_ff.last_item <= s1_tag_in.last_item;
      s1_tag_ff.row       <= s1_tag_in.row;
      s1_tag_ff.col       <= s1_tag_in.col;
   end

   // loop counters
   always_ff @(posedge clock) begin
      i_ff                <= i_in;
      j_ff                <= j_in;
      k_ff                <= k_in;
   end

   // operand stores; writes happen only in idle and reads only in run
   mmc_elem_store #(
      .DEPTH (DEPTH),
      .WIDTH (ELEM_WIDTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (load_addr),
      .wr_data (req_element_value),
      .rd_en   (issue),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mmc_elem_store #(
      .DEPTH (DEPTH),
      .WIDTH (ELEM_WIDTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (load_addr),
      .wr_data (req_element_value),
      .rd_en   (issue),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // multiply-accumulate pipeline and result register
   mmc_mac_pipe #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_mac_pipe (
      .clock         (clock),
      .reset         (reset),
      .tag_in        (s1_tag_ff),
      .a_elem        (a_rd_data),
      .b_elem        (b_rd_data),
      .err_req       (err_req),
      .rsp_valid     (rsp_valid),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_dim_error (rsp_dim_error),
      .rsp_last      (rsp_last)
   );

   // error result is the single last result of the compute that caused it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dim_error |-> rsp_last)
      else $error("dimension error result without last");

   // error result follows directly on an accepted compute request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dim_error |-> $past(start && !busy && req_kind == KIND_COMPUTE))
      else $error("dimension error result without compute request");

   // after drain, an idle core only produces error results
   assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_IDLE && $past(state_ff == SEQ_IDLE) && rsp_valid |-> rsp_dim_error)
      else $error("product result while idle");

   // stores are never written while a product is being formed
   assert property (@(posedge clock) disable iff (reset)
      state_ff != SEQ_IDLE |-> !a_wr_en && !b_wr_en)
      else $error("store write during compute");

endmodule

`default_nettype wire
